### rtl/session_table_keepalive_aging_assert.svh
// Assertion macros for the session table block.
`ifndef SESSION_TABLE_KEEPALIVE_AGING_ASSERT_SVH
`define SESSION_TABLE_KEEPALIVE_AGING_ASSERT_SVH

`ifndef SYNTHESIS
`define STKA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define STKA_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define STKA_ASSERT_IMP(lbl, ante, cons)
`define STKA_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

### rtl/stka_pkg.sv
// Types and constants shared by the session table modules.
package stka_pkg;

  localparam int CONN_W     = 16;
  localparam int TIME_W     = 8;
  localparam int SLOT_OUT_W = 4;
  localparam int CFG_IDX_W  = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEEPALIVE = 1'b1;

  localparam logic [TIME_W-1:0] TIMEOUT_RST   = 8'd60;
  localparam logic [TIME_W-1:0] KEEPALIVE_RST = 8'd5;
  localparam logic [TIME_W-1:0] AGE_MAX       = 8'hFF;

  typedef enum logic [1:0] {
    MODE_CONNECT,
    MODE_KEEPALIVE,
    MODE_DISCONNECT,
    MODE_TICK
  } mode_t;

  typedef enum logic [2:0] {
    EV_CONNECTED,
    EV_FULL,
    EV_REFRESHED,
    EV_UNKNOWN,
    EV_REMOVED,
    EV_TIMED_OUT,
    EV_SEND_KEEPALIVE,
    EV_TICK_DONE
  } event_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINAL
  } state_t;

  typedef struct packed {
    logic [CONN_W-1:0] conn;
    logic [TIME_W-1:0] age;
    logic [TIME_W-1:0] cdown;
  } entry_t;

  // per-slot decision from the evaluation unit
  typedef struct packed {
    logic              hit;
    logic              done;
    event_t            ev;
    logic [CONN_W-1:0] conn;
    logic              wr_en;
    entry_t            wr_data;
    logic              set_valid;
    logic              clr_valid;
  } slot_dec_t;

endpackage

### rtl/stka_slot_eval.sv
// Shared per-slot evaluation unit: match, allocate, age and countdown for one slot.
module stka_slot_eval (
  input  stka_pkg::mode_t                   mode,
  input  logic [stka_pkg::CONN_W-1:0]       conn_id,
  input  logic                              slot_valid,
  input  stka_pkg::entry_t                  entry,
  input  logic [stka_pkg::TIME_W-1:0]       timeout_ticks,
  input  logic [stka_pkg::TIME_W-1:0]       keepalive_period,
  output stka_pkg::slot_dec_t               dec
);
  import stka_pkg::*;

  logic [TIME_W-1:0] age_inc;
  logic [TIME_W-1:0] cd_dec;
  logic              match;

  assign age_inc = (entry.age == AGE_MAX) ? entry.age : entry.age + 8'd1;
  assign cd_dec  = entry.cdown - 8'd1;
  assign match   = slot_valid && (entry.conn == conn_id);

  always_comb begin
    dec = '0;
    unique case (mode)
      MODE_CONNECT: begin
        if (!slot_valid) begin
          dec.hit       = 1'b1;
          dec.done      = 1'b1;
          dec.ev        = EV_CONNECTED;
          dec.conn      = conn_id;
          dec.wr_en     = 1'b1;
          dec.wr_data   = '{conn: conn_id, age: '0, cdown: keepalive_period};
          dec.set_valid = 1'b1;
        end
      end
      MODE_KEEPALIVE: begin
        if (match) begin
          dec.hit     = 1'b1;
          dec.done    = 1'b1;
          dec.ev      = EV_REFRESHED;
          dec.conn    = conn_id;
          dec.wr_en   = 1'b1;
          dec.wr_data = '{conn: entry.conn, age: '0, cdown: entry.cdown};
        end
      end
      MODE_DISCONNECT: begin
        if (match) begin
          dec.hit       = 1'b1;
          dec.ev        = EV_REMOVED;
          dec.conn      = conn_id;
          dec.clr_valid = 1'b1;
        end
      end
      MODE_TICK: begin
        if (slot_valid) begin
          dec.wr_en = 1'b1;
          dec.conn  = entry.conn;
          if (age_inc > timeout_ticks) begin
            dec.hit       = 1'b1;
            dec.ev        = EV_TIMED_OUT;
            dec.clr_valid = 1'b1;
            dec.wr_data   = '{conn: entry.conn, age: age_inc, cdown: entry.cdown};
          end else if (cd_dec == '0) begin
            dec.hit     = 1'b1;
            dec.ev      = EV_SEND_KEEPALIVE;
            dec.wr_data = '{conn: entry.conn, age: age_inc, cdown: keepalive_period};
          end else begin
            dec.wr_data = '{conn: entry.conn, age: age_inc, cdown: cd_dec};
          end
        end
      end
      default: dec = '0;
    endcase
  end

endmodule

### rtl/session_table_keepalive_aging.sv
// Top level: session table with keepalive aging, sequenced slot scan.
// Usage:
//  - Command channel: drive in_mode/in_conn_id with start; the request is taken
//    at a clock edge with start high and busy low. busy stays high while the
//    table is scanned; no new request is taken meanwhile.
//  - Each request walks the slots from 0 upward, one slot per cycle, through a
//    single evaluation unit and one table read port. Connect and keepalive stop
//    at the slot they hit; misses, disconnect and tick visit all MAX_USERS
//    slots and then pass through ST_FINAL for the closing result.
//  - Results come out registered, one per cycle at most, each in the cycle
//    after the step that produces it; out_valid marks each, out_last marks
//    the final one of the request. The receiver cannot stall the block.
//  - A new request may be taken in the cycle the last result is shown.
//  - cfg_we writes timeout_ticks (index 0) or keepalive_period (index 1) at
//    once; write only while idle.
//  - Reset (rst_n low, synchronous) frees every slot and reloads 60 and 5.
`include "session_table_keepalive_aging_assert.svh"

module session_table_keepalive_aging #(
  parameter int MAX_USERS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [1:0]                          in_mode,
  input  logic [stka_pkg::CONN_W-1:0]         in_conn_id,
  output logic                                out_valid,
  output logic [2:0]                          out_event_res,
  output logic [stka_pkg::SLOT_OUT_W-1:0]     out_slot,
  output logic [stka_pkg::CONN_W-1:0]         out_conn_out,
  output logic                                out_last,
  input  logic                                cfg_we,
  input  logic [stka_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [stka_pkg::TIME_W-1:0]         cfg_wdata
);
  import stka_pkg::*;

  localparam int IDX_W = (MAX_USERS > 1) ? $clog2(MAX_USERS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_USERS - 1);

  state_t            state_r, state_nxt;
  mode_t             mode_r;
  logic [CONN_W-1:0] id_r;
  logic [IDX_W-1:0]  idx_r;
  logic [IDX_W-1:0]  rd_addr;
  logic              valid_r [MAX_USERS];
  entry_t            mem [MAX_USERS];
  entry_t            rd_data_r;
  logic              hold_v_r;
  logic [IDX_W-1:0]  hold_slot_r;
  logic [TIME_W-1:0] timeout_r;
  logic [TIME_W-1:0] kp_r;
  logic              accept;
  slot_dec_t         dec;

  logic              emit_c;
  event_t            ev_c;
  logic [IDX_W-1:0]  slot_c;
  logic [CONN_W-1:0] conn_c;
  logic              last_c;
  logic              mem_we;

  logic              out_valid_r;
  event_t            out_ev_r;
  logic [SLOT_OUT_W-1:0] out_slot_r;
  logic [CONN_W-1:0] out_conn_r;
  logic              out_last_r;

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;

  // read one slot ahead of the one being evaluated
  assign rd_addr = (state_r == ST_SCAN && idx_r != LAST_IDX) ? idx_r + IDX_W'(1) : '0;

  stka_slot_eval u_eval (
    .mode             (mode_r),
    .conn_id          (id_r),
    .slot_valid       (valid_r[idx_r]),
    .entry            (rd_data_r),
    .timeout_ticks    (timeout_r),
    .keepalive_period (kp_r),
    .dec              (dec)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (start) state_nxt = ST_SCAN;
      ST_SCAN: begin
        if (dec.done) state_nxt = ST_IDLE;
        else if (idx_r == LAST_IDX) state_nxt = ST_FINAL;
      end
      ST_FINAL: state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    emit_c = 1'b0;
    ev_c   = EV_TICK_DONE;
    slot_c = '0;
    conn_c = '0;
    last_c = 1'b0;
    mem_we = 1'b0;
    unique case (state_r)
      ST_SCAN: begin
        mem_we = dec.wr_en;
        if (dec.hit) begin
          if (mode_r == MODE_DISCONNECT) begin
            // removals are held back one hit so the final one can carry last
            emit_c = hold_v_r;
            ev_c   = EV_REMOVED;
            slot_c = hold_slot_r;
            conn_c = id_r;
          end else begin
            emit_c = 1'b1;
            ev_c   = dec.ev;
            slot_c = idx_r;
            conn_c = dec.conn;
            last_c = dec.done;
          end
        end
      end
      ST_FINAL: begin
        emit_c = 1'b1;
        last_c = 1'b1;
        unique case (mode_r)
          MODE_CONNECT: begin
            ev_c   = EV_FULL;
            conn_c = id_r;
          end
          MODE_KEEPALIVE: begin
            ev_c   = EV_UNKNOWN;
            conn_c = id_r;
          end
          MODE_DISCONNECT: begin
            ev_c   = hold_v_r ? EV_REMOVED : EV_UNKNOWN;
            slot_c = hold_v_r ? hold_slot_r : '0;
            conn_c = id_r;
          end
          MODE_TICK: ev_c = EV_TICK_DONE;
          default:   ev_c = EV_TICK_DONE;
        endcase
      end
      default: emit_c = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      hold_v_r    <= 1'b0;
      timeout_r   <= TIMEOUT_RST;
      kp_r        <= KEEPALIVE_RST;
      valid_r     <= '{default: 1'b0};
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= emit_c;
      if (cfg_we) begin
        if (cfg_index == CFG_TIMEOUT) timeout_r <= cfg_wdata;
        if (cfg_index == CFG_KEEPALIVE) kp_r <= cfg_wdata;
      end
      if (accept) begin
        hold_v_r <= 1'b0;
      end else if (state_r == ST_SCAN && mode_r == MODE_DISCONNECT && dec.hit) begin
        hold_v_r <= 1'b1;
      end
      if (state_r == ST_SCAN) begin
        if (dec.set_valid) valid_r[idx_r] <= 1'b1;
        if (dec.clr_valid) valid_r[idx_r] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r <= mode_t'(in_mode);
      id_r   <= in_conn_id;
      idx_r  <= '0;
    end else if (state_r == ST_SCAN && idx_r != LAST_IDX) begin
      idx_r <= idx_r + IDX_W'(1);
    end
    if (state_r == ST_SCAN && mode_r == MODE_DISCONNECT && dec.hit) begin
      hold_slot_r <= idx_r;
    end
    out_ev_r   <= ev_c;
    out_slot_r <= SLOT_OUT_W'(slot_c);
    out_conn_r <= conn_c;
    out_last_r <= last_c;
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[idx_r] <= dec.wr_data;
    rd_data_r <= mem[rd_addr];
  end

  assign out_valid     = out_valid_r;
  assign out_event_res = out_ev_r;
  assign out_slot      = out_slot_r;
  assign out_conn_out  = out_conn_r;
  assign out_last      = out_last_r;

  `STKA_ASSERT_IMP(a_last_frees, out_valid && out_last, !busy)
  `STKA_ASSERT_NXT(a_accept_busy, start && !busy, busy)
  `STKA_ASSERT_IMP(a_tick_done_last, out_valid && out_event_res == EV_TICK_DONE, out_last)
  `STKA_ASSERT_IMP(a_no_result_idle, !busy && !$past(busy), !out_valid)

endmodule

### tb/session_table_keepalive_aging_test.sv
// Testbench for the session table: drives requests, predicts events, checks every result.
module session_table_keepalive_aging_test;
  timeunit 1ns;
  timeprecision 1ps;

  import stka_pkg::*;

  localparam int SLOTS = 16;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct {
    event_t            ev;
    logic [3:0]        slot;
    logic [CONN_W-1:0] conn;
    logic              last;
  } session_event_t;

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  logic [1:0]            in_mode = 2'd0;
  logic [CONN_W-1:0]     in_conn_id = '0;
  logic                  out_valid;
  logic [2:0]            out_event_res;
  logic [SLOT_OUT_W-1:0] out_slot;
  logic [CONN_W-1:0]     out_conn_out;
  logic                  out_last;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [TIME_W-1:0]     cfg_wdata = '0;

  // shadow of the table and its registers
  logic              live [SLOTS];
  logic [CONN_W-1:0] owner [SLOTS];
  logic [TIME_W-1:0] idle_age [SLOTS];
  logic [TIME_W-1:0] ka_count [SLOTS];
  logic [TIME_W-1:0] timeout_limit = TIMEOUT_RST;
  logic [TIME_W-1:0] ka_period = KEEPALIVE_RST;

  session_event_t pending_events[$];
  int fail_count = 0;
  int cycle_count = 0;
  bit steady = 1'b0;

  logic [CONN_W-1:0] id_pool [8] = '{16'h0000, 16'hFFFF, 16'h0001, 16'h8000,
                                     16'h1234, 16'hA5A5, 16'h5A5A, 16'h00FF};

  session_table_keepalive_aging #(.MAX_USERS(SLOTS)) dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_mode(in_mode), .in_conn_id(in_conn_id),
    .out_valid(out_valid), .out_event_res(out_event_res), .out_slot(out_slot),
    .out_conn_out(out_conn_out), .out_last(out_last),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic void queue_event(event_t ev, int s, logic [CONN_W-1:0] conn);
    session_event_t e;
    e.ev = ev;
    e.slot = s[3:0];
    e.conn = conn;
    e.last = 1'b0;
    pending_events.push_back(e);
  endfunction

  function automatic void predict_session_events(mode_t m, logic [CONN_W-1:0] id);
    int hit;
    int removed;
    session_event_t e;
    hit = -1;
    removed = 0;
    case (m)
      MODE_CONNECT: begin
        for (int i = 0; i < SLOTS; i++)
          if (!live[i] && hit < 0) hit = i;
        if (hit >= 0) begin
          live[hit] = 1'b1;
          owner[hit] = id;
          idle_age[hit] = '0;
          ka_count[hit] = ka_period;
          queue_event(EV_CONNECTED, hit, id);
        end else begin
          queue_event(EV_FULL, 0, id);
        end
      end
      MODE_KEEPALIVE: begin
        for (int i = 0; i < SLOTS; i++)
          if (live[i] && owner[i] == id && hit < 0) hit = i;
        if (hit >= 0) begin
          idle_age[hit] = '0;
          queue_event(EV_REFRESHED, hit, id);
        end else begin
          queue_event(EV_UNKNOWN, 0, id);
        end
      end
      MODE_DISCONNECT: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (live[i] && owner[i] == id) begin
            live[i] = 1'b0;
            removed++;
            queue_event(EV_REMOVED, i, id);
          end
        end
        if (removed == 0) queue_event(EV_UNKNOWN, 0, id);
      end
      default: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (live[i]) begin
            if (idle_age[i] != AGE_MAX) idle_age[i] = idle_age[i] + 8'd1;
            if (idle_age[i] > timeout_limit) begin
              live[i] = 1'b0;
              queue_event(EV_TIMED_OUT, i, owner[i]);
            end else begin
              ka_count[i] = ka_count[i] - 8'd1;
              if (ka_count[i] == '0) begin
                ka_count[i] = ka_period;
                queue_event(EV_SEND_KEEPALIVE, i, owner[i]);
              end
            end
          end
        end
        queue_event(EV_TICK_DONE, 0, '0);
      end
    endcase
    e = pending_events.pop_back();
    e.last = 1'b1;
    pending_events.push_back(e);
  endfunction

  always @(posedge clk) begin
    session_event_t e;
    if (rst_n && out_valid) begin
      if (pending_events.size() == 0) begin
        $error("unexpected result: event_res %0d slot %0d conn_out %h",
               out_event_res, out_slot, out_conn_out);
        fail_count++;
      end else begin
        e = pending_events.pop_front();
        if (out_event_res !== e.ev) begin
          $error("event_res mismatch: expected %0d, got %0d", e.ev, out_event_res);
          fail_count++;
        end
        if (out_slot !== e.slot) begin
          $error("slot mismatch: expected %0d, got %0d", e.slot, out_slot);
          fail_count++;
        end
        if (out_conn_out !== e.conn) begin
          $error("conn_out mismatch: expected %h, got %h", e.conn, out_conn_out);
          fail_count++;
        end
        if (out_last !== e.last) begin
          $error("last mismatch: expected %0d, got %0d", e.last, out_last);
          fail_count++;
        end
      end
    end
  end

  // mostly short gaps, a few long ones; none while steady
  task automatic send_request(mode_t m, logic [CONN_W-1:0] id);
    int r;
    int gap;
    start <= 1'b1;
    in_mode <= m;
    in_conn_id <= id;
    do @(posedge clk); while (busy);
    predict_session_events(m, id);
    r = $urandom_range(0, 99);
    gap = (steady || r < 45) ? 0 : (r < 90) ? $urandom_range(1, 3) : $urandom_range(8, 30);
    if (gap > 0) begin
      start <= 1'b0;
      in_mode <= 2'($urandom);
      in_conn_id <= CONN_W'($urandom);
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_quiet();
    start <= 1'b0;
    do @(posedge clk); while (pending_events.size() != 0);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [TIME_W-1:0] val);
    wait_quiet();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_TIMEOUT) timeout_limit = val;
    else ka_period = val;
  endtask

  function automatic logic [CONN_W-1:0] pick_id();
    if ($urandom_range(0, 99) < 80) return id_pool[3'($urandom_range(0, 7))];
    return CONN_W'($urandom);
  endfunction

  task automatic test_connect_and_refresh();
    send_request(MODE_CONNECT, 16'h0000);
    send_request(MODE_CONNECT, 16'hFFFF);
    send_request(MODE_KEEPALIVE, 16'hFFFF);
    send_request(MODE_KEEPALIVE, 16'h1234);
    send_request(MODE_DISCONNECT, 16'h5555);
    send_request(MODE_DISCONNECT, 16'h0000);
    send_request(MODE_CONNECT, 16'hA5A5);
  endtask

  task automatic test_full_table_and_duplicates();
    for (int i = 2; i < SLOTS; i++)
      send_request(MODE_CONNECT, (i < 4) ? 16'hA5A5 : 16'h5A00 + CONN_W'(i));
    send_request(MODE_CONNECT, 16'h7E7E);
    send_request(MODE_KEEPALIVE, 16'hA5A5);
    send_request(MODE_DISCONNECT, 16'hA5A5);
  endtask

  task automatic test_tick_extremes();
    write_register(CFG_TIMEOUT, 8'd1);
    write_register(CFG_KEEPALIVE, 8'd1);
    send_request(MODE_CONNECT, 16'h1111);
    send_request(MODE_TICK, 16'hFFFF);
    send_request(MODE_TICK, 16'h0000);
    // zero timeout drops every live slot on the next tick
    send_request(MODE_CONNECT, 16'h2222);
    write_register(CFG_TIMEOUT, 8'd0);
    send_request(MODE_TICK, 16'h0000);
    write_register(CFG_TIMEOUT, 8'd255);
    write_register(CFG_KEEPALIVE, 8'd255);
    send_request(MODE_CONNECT, 16'h3333);
    write_register(CFG_KEEPALIVE, 8'd0);
    send_request(MODE_CONNECT, 16'h4444);
    send_request(MODE_TICK, 16'h0000);
  endtask

  task automatic test_random_traffic();
    logic [TIME_W-1:0] tmo [6] = '{8'd60, 8'd1, 8'd254, 8'd2, 8'd0, 8'd0};
    logic [TIME_W-1:0] per [6] = '{8'd5, 8'd1, 8'd255, 8'd3, 8'd0, 8'd0};
    int r;
    mode_t m;
    tmo[4] = TIME_W'($urandom_range(1, 254));
    per[4] = TIME_W'($urandom_range(1, 255));
    tmo[5] = TIME_W'($urandom_range(3, 20));
    per[5] = TIME_W'($urandom_range(1, 4));
    for (int p = 0; p < 6; p++) begin
      write_register(CFG_TIMEOUT, tmo[p]);
      write_register(CFG_KEEPALIVE, per[p]);
      steady = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < 20; n++) begin
        r = $urandom_range(0, 99);
        m = (r < 35) ? MODE_CONNECT : (r < 55) ? MODE_KEEPALIVE :
            (r < 70) ? MODE_DISCONNECT : MODE_TICK;
        send_request(m, (m == MODE_TICK) ? CONN_W'($urandom) : pick_id());
      end
      steady = 1'b0;
    end
  endtask

  // idle run: zero-period countdown wraps past zero, then a lowered timeout drops stale slots
  task automatic test_idle_aging();
    write_register(CFG_TIMEOUT, 8'd0);
    send_request(MODE_TICK, 16'h0000);
    write_register(CFG_TIMEOUT, 8'd255);
    write_register(CFG_KEEPALIVE, 8'd0);
    send_request(MODE_CONNECT, 16'hC3C3);
    send_request(MODE_CONNECT, 16'h3C3C);
    for (int n = 0; n < 24; n++) begin
      if (n == 10) send_request(MODE_KEEPALIVE, 16'hC3C3);
      if ($urandom_range(0, 19) == 0) send_request(MODE_KEEPALIVE, 16'h0F0F);
      send_request(MODE_TICK, CONN_W'($urandom));
    end
    write_register(CFG_TIMEOUT, 8'd20);
    send_request(MODE_TICK, 16'h0000);
    write_register(CFG_TIMEOUT, TIMEOUT_RST);
    write_register(CFG_KEEPALIVE, KEEPALIVE_RST);
    send_request(MODE_CONNECT, 16'hFFFF);
    send_request(MODE_TICK, 16'h0000);
  endtask

  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      live[i] = 1'b0;
      owner[i] = '0;
      idle_age[i] = '0;
      ka_count[i] = '0;
    end
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_connect_and_refresh();
    test_full_table_and_duplicates();
    test_tick_extremes();
    test_random_traffic();
    test_idle_aging();
    wait_quiet();
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+rtl
rtl/stka_pkg.sv
rtl/stka_slot_eval.sv
rtl/session_table_keepalive_aging.sv
tb/session_table_keepalive_aging_test.sv
